/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold on every enabled clock edge
`define BSPF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bspf assertion failed");
// condition must never be seen on an enabled clock edge
`define BSPF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bspf forbidden condition seen");
`else
`define BSPF_ASSERT(lbl, clk, rst_n, prop)
`define BSPF_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* rtl/core/bspf_pkg.sv */
// ----------------------------------------------------------------------------
// bspf_pkg
// Types, register indexes and byte helpers for the pattern finder.
// ----------------------------------------------------------------------------
package bspf_pkg;

  localparam int PAT_W      = 64;
  localparam int PLEN_W     = 5;
  localparam int OFFSET_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PAT_BYTES  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CASE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET    = 3'd4;

  typedef struct packed {
    logic [PAT_W-1:0]    pattern_low;
    logic [PAT_W-1:0]    pattern_high;
    logic [PLEN_W-1:0]   pattern_length;
    logic                ignore_case;
    logic [OFFSET_W-1:0] base_offset;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic                valid;
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
  } res_t;

  // CP866 case folding
  function automatic logic [7:0] fold866(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end else if (c >= 8'hA0 && c <= 8'hAF) begin
      r = c - 8'h20;
    end else if (c >= 8'hE0 && c <= 8'hEF) begin
      r = c - 8'h50;
    end else if (c >= 8'hF0 && c <= 8'hF7) begin
      r = c & 8'hFE;
    end
    return r;
  endfunction

  // pattern byte k; bytes past the two registers read as zero
  function automatic logic [7:0] pattern_byte(input cfg_t c, input int unsigned k);
    logic [7:0] r;
    r = 8'h00;
    if (k < 8) begin
      r = 8'(c.pattern_low >> (8 * k));
    end else if (k < PAT_BYTES) begin
      r = 8'(c.pattern_high >> (8 * (k - 8)));
    end
    return r;
  endfunction

endpackage

/* rtl/core/bspf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bspf_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module bspf_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bspf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bspf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output bspf_pkg::cfg_t                     cfg
);
  import bspf_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LOW:    cfg_nxt.pattern_low    = cfg_wdata[PAT_W-1:0];
        REG_PATTERN_HIGH:   cfg_nxt.pattern_high   = cfg_wdata[PAT_W-1:0];
        REG_PATTERN_LENGTH: cfg_nxt.pattern_length = cfg_wdata[PLEN_W-1:0];
        REG_IGNORE_CASE:    cfg_nxt.ignore_case    = cfg_wdata[0];
        REG_BASE_OFFSET:    cfg_nxt.base_offset    = cfg_wdata[OFFSET_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.pattern_length <= PLEN_W'(1);
      cfg_r.ignore_case    <= 1'b0;
      cfg_r.base_offset    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/bspf_in_stage.sv */
// ----------------------------------------------------------------------------
// bspf_in_stage
// Input register; holds one byte until the compare stage can take it.
// ----------------------------------------------------------------------------
module bspf_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_byte,
  input  logic            out_free,
  output logic            adv,
  output bspf_pkg::item_t item
);
  import bspf_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       take;

  assign adv      = valid_r && out_free;
  assign in_stall = valid_r && !out_free;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign item.valid     = valid_r;
  assign item.data_byte = data_r;
  assign item.last_byte = last_r;

endmodule

/* rtl/core/bspf_match_core.sv */
// ----------------------------------------------------------------------------
// bspf_match_core
// Byte window, stream counters and the parallel window/pattern compare.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bspf_match_core #(
  parameter int MAX_PATTERN = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  bspf_pkg::item_t item,
  input  bspf_pkg::cfg_t  cfg,
  output bspf_pkg::res_t  res
);
  import bspf_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int CW = (LW > PLEN_W) ? LW : PLEN_W;
  localparam int WB = MAX_PATTERN * 8;

  logic [WB-1:0]       window_r, window_nxt, window_sh;
  logic [OFFSET_W-1:0] bytes_seen_r, bytes_seen_nxt, seen_inc;
  logic                match_done_r, match_done_nxt;

  logic [CW-1:0]       plen_ext;
  logic [LW-1:0]       len, shamt;
  logic [LW+2:0]       shbits;
  logic [WB-1:0]       pat_rev, pat_aligned;
  logic [MAX_PATTERN-1:0] pos_ok;
  logic                len_zero, enough, hit;
  logic [OFFSET_W-1:0] adj, offset;

  // effective length, clamped to the window depth
  assign plen_ext = CW'(cfg.pattern_length);
  assign len      = (plen_ext > CW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : LW'(plen_ext);
  assign len_zero = (len == '0);

  assign window_sh = (window_r << 8) | WB'(item.data_byte);
  assign seen_inc  = bytes_seen_r + OFFSET_W'(1);

  // pattern byte-reversed, then shifted so byte k lines up with window age len-1-k
  always_comb begin
    pat_rev = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pat_rev[8*(MAX_PATTERN-1-k) +: 8] = pattern_byte(cfg, k);
    end
  end

  assign shamt       = LW'(MAX_PATTERN) - len;
  assign shbits      = {shamt, 3'b000};
  assign pat_aligned = pat_rev >> shbits;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      logic [7:0] wb;
      logic [7:0] pb;
      wb = window_sh[8*j +: 8];
      pb = pat_aligned[8*j +: 8];
      if (cfg.ignore_case) begin
        wb = fold866(wb);
        pb = fold866(pb);
      end
      pos_ok[j] = (LW'(j) >= len) || (wb == pb);
    end
  end

  assign enough = (seen_inc >= OFFSET_W'(len));
  assign hit    = len_zero || (enough && (&pos_ok));
  assign adj    = len_zero ? '0 : (OFFSET_W'(1) - OFFSET_W'(len));
  assign offset = cfg.base_offset + bytes_seen_r + adj;

  assign res.valid        = adv && !match_done_r && (hit || item.last_byte);
  assign res.found        = hit;
  assign res.match_offset = hit ? offset : '0;

  always_comb begin
    window_nxt     = window_r;
    bytes_seen_nxt = bytes_seen_r;
    match_done_nxt = match_done_r;
    if (adv) begin
      if (!match_done_r) begin
        window_nxt     = window_sh;
        bytes_seen_nxt = seen_inc;
        match_done_nxt = hit;
      end
      if (item.last_byte) begin
        bytes_seen_nxt = '0;
        match_done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= '0;
      bytes_seen_r <= '0;
      match_done_r <= 1'b0;
    end else begin
      window_r     <= window_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      match_done_r <= match_done_nxt;
    end
  end

  `BSPF_ASSERT(a_adv_valid, clk, rst_n, adv |-> item.valid)
  `BSPF_ASSERT(a_done_after_hit, clk, rst_n, (res.valid && res.found && !item.last_byte) |=> match_done_r)
  `BSPF_ASSERT_NEVER(a_quiet_after_done, clk, rst_n, match_done_r && res.valid)
  `BSPF_ASSERT(a_clear_on_last, clk, rst_n, (adv && item.last_byte) |=> (bytes_seen_r == '0 && !match_done_r))
  `BSPF_ASSERT(a_last_reports, clk, rst_n, (adv && item.last_byte && !match_done_r) |-> res.valid)

endmodule

/* rtl/core/bspf_out_stage.sv */
// ----------------------------------------------------------------------------
// bspf_out_stage
// Result register on the output channel.
// ----------------------------------------------------------------------------
module bspf_out_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bspf_pkg::res_t                    res,
  output logic                              out_free,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [bspf_pkg::OFFSET_W-1:0]     out_match_offset
);
  import bspf_pkg::*;

  logic                valid_r, valid_nxt;
  logic                found_r;
  logic [OFFSET_W-1:0] offset_r;

  assign out_free  = !valid_r || !out_stall;
  assign valid_nxt = out_free ? res.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      found_r  <= res.found;
      offset_r <= res.match_offset;
    end
  end

  assign out_valid        = valid_r;
  assign out_found        = found_r;
  assign out_match_offset = offset_r;

endmodule

/* rtl/core/byte_stream_pattern_finder_unit.sv */
// ----------------------------------------------------------------------------
// byte_stream_pattern_finder_unit
// Streaming search for a configured byte pattern of up to 16 bytes.
// ----------------------------------------------------------------------------
// Accepts one byte per clock and keeps going as long as the result side does
// not stall. A byte is registered on transfer, compared against the whole
// pattern once the result register can take it (window shift, optional CP866
// folding and a full-width equality check in one pass) and the result is
// registered. Each stream yields at most one result: found with the absolute
// start offset on the first match, or not-found at the marked last byte. Bytes
// after a match are consumed silently up to the last byte. The user writes
// pattern, length, case mode and base offset between streams through the cfg
// port; the block itself does not enforce this.
module byte_stream_pattern_finder_unit #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bspf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bspf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_last_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [bspf_pkg::OFFSET_W-1:0]     out_match_offset
);
  import bspf_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res;
  logic  out_free;
  logic  adv;

  bspf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bspf_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_free     (out_free),
    .adv          (adv),
    .item         (item)
  );

  bspf_match_core #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  bspf_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_match_offset (out_match_offset)
  );

endmodule
